FILE: design/gbnr_pkg.sv
package gbnr_pkg;

   // Sizing
   localparam int MAX_SEQ_BITS_DEF = 16;
   localparam int QUEUE_DEPTH      = 2;

   // Field widths
   localparam int OPCODE_W    = 2;
   localparam int SEQ_NUM_W   = 16;
   localparam int KIND_W      = 2;
   localparam int WINDOW_W    = 16;
   localparam int ACK_EVERY_W = 8;
   localparam int SEQ_BITS_W  = 5;
   localparam int BUF_LIMIT_W = 10;

   // Register port
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;

   // Register indexes (paddr[3:2])
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ACK_EVERY    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SEQ_BITS     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BUFFER_LIMIT = 2'd3;

   // Register reset values
   localparam logic [WINDOW_W-1:0]    WINDOW_SIZE_RST  = 16'd7;
   localparam logic [ACK_EVERY_W-1:0] ACK_EVERY_RST    = 8'd1;
   localparam logic [SEQ_BITS_W-1:0]  SEQ_BITS_RST     = 5'd3;
   localparam logic [BUF_LIMIT_W-1:0] BUFFER_LIMIT_RST = 10'd16;

   // Incoming opcodes
   localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_DATA  = 2'd1;

   // Reply kinds
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RR    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RNR   = 2'd2;

   localparam logic [ACK_EVERY_W-1:0] SINCE_ACK_MAX = 8'd255;

   typedef struct packed {
      logic [OPCODE_W-1:0]  opcode;
      logic [SEQ_NUM_W-1:0] seq_num;
      logic                 frame_bad;
   } req_item_type;

   typedef struct packed {
      logic [KIND_W-1:0]    reply_kind;
      logic [WINDOW_W-1:0]  window_out;
      logic [SEQ_NUM_W-1:0] ack_num;
   } rsp_item_type;

   typedef struct packed {
      logic [WINDOW_W-1:0]    window_size;
      logic [ACK_EVERY_W-1:0] ack_every;
      logic [SEQ_BITS_W-1:0]  seq_bits;
      logic [BUF_LIMIT_W-1:0] buffer_limit;
   } cfg_type;

   typedef enum logic {
      CLS_QUERY = 1'b0,
      CLS_DATA  = 1'b1
   } cls_type;

   typedef struct packed {
      cls_type              cls;
      logic [SEQ_NUM_W-1:0] seq_num;
   } q_entry_type;

endpackage

FILE: design/gbnr_front.sv
module gbnr_front
   import gbnr_pkg::*;
(
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   input  logic         q_full,
   output logic         q_push,
   output q_entry_type  q_entry
);

   logic accepted;
   logic needs_work;

   // take an item whenever the queue has room
   assign req_stall = q_full;
   assign accepted  = req_valid && !q_full;

   // classify: queries and good data frames go on; bad frames and other opcodes drop here
   always_comb begin
      q_entry.seq_num = req_item.seq_num;
      unique case (req_item.opcode)
         OP_QUERY: begin
            needs_work  = 1'b1;
            q_entry.cls = CLS_QUERY;
         end
         OP_DATA: begin
            needs_work  = !req_item.frame_bad;
            q_entry.cls = CLS_DATA;
         end
         default: begin
            needs_work  = 1'b0;
            q_entry.cls = CLS_DATA;
         end
      endcase
   end

   assign q_push = accepted && needs_work;

endmodule

FILE: design/gbnr_queue.sv
module gbnr_queue
   import gbnr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_entry,
   output logic        full,
   input  logic        pop,
   output logic        head_valid,
   output q_entry_type head_entry
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

   q_entry_type entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full       = (count_ff == FullCnt);
   assign head_valid = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];

   // pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CntW'(push) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: design/gbnr_back.sv
module gbnr_back
   import gbnr_pkg::*;
#(
   parameter int MAX_SEQ_BITS = MAX_SEQ_BITS_DEF
)
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         head_valid,
   input  q_entry_type  head_entry,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   localparam int BitsW = 6;

   logic [MAX_SEQ_BITS-1:0] expected_ff, expected_in;
   logic [ACK_EVERY_W-1:0]  since_ack_ff, since_ack_in;
   logic [BUF_LIMIT_W-1:0]  buffered_ff, buffered_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_item_type            rsp_item_ff;

   logic [BitsW-1:0]        bits;
   logic [MAX_SEQ_BITS-1:0] mask;
   logic [MAX_SEQ_BITS-1:0] exp_m;
   logic [MAX_SEQ_BITS-1:0] exp_inc;
   logic [MAX_SEQ_BITS-1:0] exp_dec;
   logic [ACK_EVERY_W-1:0]  since_sat;
   logic                    in_order;
   logic                    slot_free;
   logic                    produce;
   rsp_item_type            result;

   // sequence space: clamp width to 1..MAX_SEQ_BITS, build mask
   always_comb begin
      if (cfg.seq_bits == '0) begin
         bits = BitsW'(1);
      end else if (BitsW'(cfg.seq_bits) > BitsW'(MAX_SEQ_BITS)) begin
         bits = BitsW'(MAX_SEQ_BITS);
      end else begin
         bits = BitsW'(cfg.seq_bits);
      end
      for (int i = 0; i < MAX_SEQ_BITS; i++) begin
         mask[i] = (BitsW'(i) < bits);
      end
   end

   assign exp_m     = expected_ff & mask;
   assign exp_inc   = (exp_m + 1'b1) & mask;
   assign exp_dec   = (exp_m - 1'b1) & mask;
   assign in_order  = (32'(head_entry.seq_num) == 32'(exp_m));
   assign since_sat = (since_ack_ff == SINCE_ACK_MAX) ? since_ack_ff : since_ack_ff + 1'b1;

   // one item a cycle while the output slot is free or being emptied
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign pop       = head_valid && slot_free;

   // receive state update and reply
   always_comb begin
      expected_in  = expected_ff;
      since_ack_in = since_ack_ff;
      buffered_in  = buffered_ff;
      produce      = 1'b0;
      result       = '0;
      if (pop) begin
         case (head_entry.cls)
            CLS_QUERY: begin
               produce           = 1'b1;
               result.reply_kind = KIND_QUERY;
               result.window_out = cfg.window_size;
            end
            default: begin
               if (buffered_ff >= cfg.buffer_limit) begin
                  // buffer at limit: refuse
                  produce           = 1'b1;
                  result.reply_kind = KIND_RNR;
               end else if (in_order) begin
                  buffered_in  = buffered_ff + 1'b1;
                  expected_in  = exp_inc;
                  since_ack_in = since_sat;
                  // buffer is non-empty now; ack once the count since the last ack reaches ack_every
                  if (since_sat >= cfg.ack_every) begin
                     produce           = 1'b1;
                     result.reply_kind = KIND_RR;
                     result.ack_num    = SEQ_NUM_W'(exp_m);
                     since_ack_in      = '0;
                  end
               end else if (!(exp_m == '0 && buffered_ff == '0)) begin
                  // out of order: forced ack of the last in-order frame
                  produce           = 1'b1;
                  result.reply_kind = KIND_RR;
                  result.ack_num    = SEQ_NUM_W'(exp_dec);
                  since_ack_in      = '0;
               end
            end
         endcase
      end
      rsp_valid_in = produce || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff  <= '0;
         since_ack_ff <= '0;
         buffered_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         expected_ff  <= expected_in;
         since_ack_ff <= since_ack_in;
         buffered_ff  <= buffered_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (produce) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

FILE: design/go_back_n_receiver_top.sv
// Go-Back-N receiver.
// Throughput: one item per cycle while the queue is not full; the front classifies, a two-entry queue feeds the back.
// An accepted item is stored in the queue, then handled by the back, whose reply is registered.
// Bad data frames and other opcodes are dropped in the front and give no result.
// Synchronous active-high reset clears sequence state, counters, queue and output valid,
// and loads the register defaults (window 7, ack every 1, 3 sequence bits, limit 16).
module go_back_n_receiver_top
   import gbnr_pkg::*;
#(
   parameter int MAX_SEQ_BITS = MAX_SEQ_BITS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_item,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type              cfg_ff, cfg_in;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic                 csr_write;
   logic                 q_full;
   logic                 q_push;
   q_entry_type          q_entry;
   logic                 q_pop;
   logic                 head_valid;
   q_entry_type          head_entry;

   // register port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_WINDOW_SIZE:  cfg_in.window_size  = csr_pwdata[WINDOW_W-1:0];
            REG_ACK_EVERY:    cfg_in.ack_every    = csr_pwdata[ACK_EVERY_W-1:0];
            REG_SEQ_BITS:     cfg_in.seq_bits     = csr_pwdata[SEQ_BITS_W-1:0];
            REG_BUFFER_LIMIT: cfg_in.buffer_limit = csr_pwdata[BUF_LIMIT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_WINDOW_SIZE:  csr_prdata = CSR_DATA_W'(cfg_ff.window_size);
         REG_ACK_EVERY:    csr_prdata = CSR_DATA_W'(cfg_ff.ack_every);
         REG_SEQ_BITS:     csr_prdata = CSR_DATA_W'(cfg_ff.seq_bits);
         REG_BUFFER_LIMIT: csr_prdata = CSR_DATA_W'(cfg_ff.buffer_limit);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_size  <= WINDOW_SIZE_RST;
         cfg_ff.ack_every    <= ACK_EVERY_RST;
         cfg_ff.seq_bits     <= SEQ_BITS_RST;
         cfg_ff.buffer_limit <= BUFFER_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gbnr_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   gbnr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   gbnr_back #(
      .MAX_SEQ_BITS (MAX_SEQ_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

endmodule

FILE: design/gbnr_checker.sv
module gbnr_checker
   import gbnr_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_item
);

   // a stalled reply holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled reply changed");

   // reset empties the output slot
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("reply valid right after reset");

   // only the three reply kinds appear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.reply_kind == KIND_QUERY || rsp_item.reply_kind == KIND_RR
                     || rsp_item.reply_kind == KIND_RNR))
      else $error("unknown reply kind");

   // unused reply fields read zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.reply_kind == KIND_QUERY && rsp_item.ack_num == '0)
                    || (rsp_item.reply_kind == KIND_RR && rsp_item.window_out == '0)
                    || (rsp_item.reply_kind == KIND_RNR && rsp_item.window_out == '0
                        && rsp_item.ack_num == '0))
      else $error("reply carries stray field data");

endmodule

bind go_back_n_receiver_top gbnr_checker u_checker (.*);
